// ===== design/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types, character codes and window sizes for the include directive
// scanner.
// ----------------------------------------------------------------------------
package ids_pkg;

	localparam int LOOKAHEAD_DEPTH   = 6;
	localparam int POSITION_BITS_DEF = 32;
	localparam int SPAN              = LOOKAHEAD_DEPTH + 1;
	localparam int FILL_W            = $clog2(SPAN + 1);
	localparam int KW_LEN            = 7;

	typedef logic [7:0] ids_byte_t;
	typedef ids_byte_t [SPAN-1:0] ids_win_t;
	typedef logic [FILL_W-1:0] ids_fill_t;

	localparam ids_byte_t CH_HASH  = 8'h23;
	localparam ids_byte_t CH_QUOTE = 8'h22;
	localparam ids_byte_t CH_LT    = 8'h3C;
	localparam ids_byte_t CH_GT    = 8'h3E;
	localparam ids_byte_t CH_SLASH = 8'h2F;
	localparam ids_byte_t CH_STAR  = 8'h2A;
	localparam ids_byte_t CH_CR    = 8'h0D;
	localparam ids_byte_t CH_LF    = 8'h0A;

	localparam ids_byte_t KW_INCLUDE [KW_LEN] = '{
		8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65
	};

	localparam ids_fill_t TOK_ONE = ids_fill_t'(1);
	localparam ids_fill_t TOK_TWO = ids_fill_t'(2);
	localparam ids_fill_t TOK_KW  = ids_fill_t'(KW_LEN);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} ids_in_t;

	typedef struct packed {
		logic [31:0] line_number;
		logic [31:0] directive_position;
		logic [31:0] name_start;
		logic [31:0] name_length;
		logic        is_system;
	} ids_out_t;

	typedef struct packed {
		logic line_cmt;
		logic block_cmt;
		logic in_incl;
		logic dir_open;
		logic quote_open;
		logic angle_open;
	} ids_flags_t;

endpackage

// ===== design/ids_token.sv =====
// ----------------------------------------------------------------------------
// ids_token
// Resolves one token at the head of the byte window and gives the next scan
// state, the token length and an include record when one completes.
// ----------------------------------------------------------------------------
module ids_token #(
	parameter int POSITION_BITS = ids_pkg::POSITION_BITS_DEF
) (
	input  ids_pkg::ids_win_t    win,
	input  ids_pkg::ids_fill_t   avail,
	input  ids_pkg::ids_flags_t  flags,
	input  logic [POSITION_BITS-1:0] text_pos,
	input  logic [POSITION_BITS-1:0] dir_off,
	input  logic [POSITION_BITS-1:0] quote_off,
	input  logic [POSITION_BITS-1:0] angle_off,
	input  logic [31:0]          line_cnt,
	output ids_pkg::ids_flags_t  flags_nx,
	output logic [POSITION_BITS-1:0] text_pos_nx,
	output logic [POSITION_BITS-1:0] dir_off_nx,
	output logic [POSITION_BITS-1:0] quote_off_nx,
	output logic [POSITION_BITS-1:0] angle_off_nx,
	output logic [31:0]          line_cnt_nx,
	output ids_pkg::ids_fill_t   tok_len,
	output logic                 hit,
	output ids_pkg::ids_out_t    record
);
	import ids_pkg::*;

	logic                     comment;
	logic                     quoted;
	logic                     kw;
	logic                     two;
	logic                     sys;
	ids_byte_t                c0;
	ids_byte_t                c1;
	logic [POSITION_BITS-1:0] open_sel;
	logic [POSITION_BITS-1:0] name_beg;
	logic [POSITION_BITS-1:0] name_len;

	assign comment = flags.line_cmt | flags.block_cmt;
	assign quoted  = flags.quote_open | flags.angle_open;
	assign c0      = win[0];
	assign c1      = win[1];
	assign two     = avail >= TOK_TWO;

	always_comb begin
		kw = (avail >= TOK_KW);
		for (int i = 0; i < KW_LEN; i++) begin
			if (win[i] != KW_INCLUDE[i]) begin
				kw = 1'b0;
			end
		end
	end

	always_comb begin
		flags_nx     = flags;
		dir_off_nx   = dir_off;
		quote_off_nx = quote_off;
		angle_off_nx = angle_off;
		line_cnt_nx  = line_cnt;
		tok_len      = TOK_ONE;
		hit          = 1'b0;
		sys          = 1'b0;
		if (kw) begin
			if (!comment && !flags.in_incl && !quoted && flags.dir_open) begin
				flags_nx.in_incl = 1'b1;
			end
			tok_len = TOK_KW;
		end else if (c0 == CH_HASH) begin
			if (!quoted && !comment) begin
				flags_nx.dir_open = 1'b1;
				dir_off_nx        = text_pos;
			end
		end else if (c0 == CH_QUOTE) begin
			if (flags.quote_open) begin
				if (!flags.angle_open) begin
					if (flags.in_incl) begin
						hit              = 1'b1;
						flags_nx.dir_open = 1'b0;
						flags_nx.in_incl  = 1'b0;
					end
					flags_nx.quote_open = 1'b0;
				end
			end else if (!comment && !flags.angle_open) begin
				flags_nx.quote_open = 1'b1;
				quote_off_nx        = text_pos;
			end
		end else if (c0 == CH_LT) begin
			if (!comment && !quoted) begin
				flags_nx.angle_open = 1'b1;
				angle_off_nx        = text_pos;
			end
		end else if (c0 == CH_GT) begin
			if (flags.angle_open && !flags.quote_open) begin
				if (flags.in_incl) begin
					hit               = 1'b1;
					sys               = 1'b1;
					flags_nx.dir_open = 1'b0;
					flags_nx.in_incl  = 1'b0;
				end
				flags_nx.angle_open = 1'b0;
			end
		end else if (two && c0 == CH_SLASH && c1 == CH_SLASH) begin
			if (!quoted && !comment) begin
				flags_nx.line_cmt   = 1'b1;
				flags_nx.quote_open = 1'b0;
				flags_nx.angle_open = 1'b0;
				flags_nx.dir_open   = 1'b0;
				flags_nx.in_incl    = 1'b0;
			end
			tok_len = TOK_TWO;
		end else if (two && c0 == CH_SLASH && c1 == CH_STAR) begin
			if (!quoted && !comment) begin
				flags_nx.block_cmt  = 1'b1;
				flags_nx.quote_open = 1'b0;
				flags_nx.angle_open = 1'b0;
				flags_nx.dir_open   = 1'b0;
				flags_nx.in_incl    = 1'b0;
			end
			tok_len = TOK_TWO;
		end else if (two && c0 == CH_STAR && c1 == CH_SLASH) begin
			if (flags.block_cmt) begin
				flags_nx.block_cmt = 1'b0;
				flags_nx.line_cmt  = 1'b0;
			end
			tok_len = TOK_TWO;
		end else if (c0 == CH_CR || c0 == CH_LF) begin
			if (two && c0 == CH_CR && c1 == CH_LF) begin
				tok_len = TOK_TWO;
			end
			flags_nx.line_cmt   = 1'b0;
			flags_nx.quote_open = 1'b0;
			flags_nx.angle_open = 1'b0;
			flags_nx.dir_open   = 1'b0;
			flags_nx.in_incl    = 1'b0;
			line_cnt_nx         = line_cnt + 32'd1;
		end
	end

	assign text_pos_nx = text_pos + POSITION_BITS'(tok_len);
	assign open_sel    = sys ? angle_off : quote_off;
	assign name_beg    = open_sel + POSITION_BITS'(1);
	assign name_len    = text_pos - open_sel - POSITION_BITS'(1);

	assign record.line_number        = line_cnt;
	assign record.directive_position = 32'(dir_off);
	assign record.name_start         = 32'(name_beg);
	assign record.name_length        = 32'(name_len);
	assign record.is_system          = sys;

endmodule

// ===== design/include_directive_scanner.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner
// Scans source text a byte per word and emits one record per completed
// include directive.
//
// Takes one text byte per cycle while nothing stalls. A byte lands in an input
// register and then moves into a seven-byte window; once the window is full,
// one token unit resolves the token at its head in the same cycle as the byte
// that filled it moves in, and a record for a completed include is then loaded
// into the result register. A result that waits for the receiver holds the input.
// A byte marked end of text starts a flush in which the token unit resolves
// one pending token per cycle while the result can move on; a following byte
// can wait in the input register but enters the window only when the flush is
// done. Configuration writes are taken in any cycle and load the line counter.
// ----------------------------------------------------------------------------
module include_directive_scanner #(
	parameter int POSITION_BITS = ids_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  ids_pkg::ids_in_t  char_data,
	output logic              rec_valid,
	input  logic              rec_ready,
	output ids_pkg::ids_out_t rec_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import ids_pkg::*;

	logic                     valid_s1;
	ids_in_t                  char_s1;
	ids_win_t                 win_q;
	ids_fill_t                fill_q;
	logic                     flush_q;
	logic                     flush_hit_q;
	ids_flags_t               flags_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] dir_q;
	logic [POSITION_BITS-1:0] quote_q;
	logic [POSITION_BITS-1:0] angle_q;
	logic [31:0]              line_q;
	logic                     rec_valid_q;
	ids_out_t                 rec_q;

	logic                     out_free;
	logic                     fire;
	logic                     step_flush;
	logic                     run_tok;
	logic                     rec_load;
	ids_win_t                 buf_win;
	ids_win_t                 shifted;
	ids_fill_t                avail;
	ids_flags_t               flags_nx;
	logic [POSITION_BITS-1:0] pos_nx;
	logic [POSITION_BITS-1:0] dir_nx;
	logic [POSITION_BITS-1:0] quote_nx;
	logic [POSITION_BITS-1:0] angle_nx;
	logic [31:0]              line_nx;
	ids_fill_t                tok_len;
	logic                     hit;
	ids_out_t                 record;

	assign out_free   = !rec_valid_q || rec_ready;
	assign fire       = valid_s1 && !flush_q && out_free;
	assign step_flush = flush_q && out_free;
	assign run_tok    = (fire && !char_s1.end_of_text && fill_q == ids_fill_t'(SPAN - 1))
		|| step_flush;
	assign rec_load   = run_tok && hit && !(step_flush && flush_hit_q);
	assign avail      = fire ? fill_q + TOK_ONE : fill_q;

	assign char_ready = !valid_s1 || fire;
	assign cfg_ready  = 1'b1;
	assign rec_valid  = rec_valid_q;
	assign rec_data   = rec_q;

	always_comb begin
		buf_win = win_q;
		for (int i = 0; i < SPAN; i++) begin
			if (fire && fill_q == ids_fill_t'(i)) begin
				buf_win[i] = char_s1.text_byte;
			end
		end
	end

	always_comb begin
		shifted = buf_win;
		case (tok_len)
			TOK_ONE: begin
				for (int i = 0; i < SPAN - 1; i++) begin
					shifted[i] = buf_win[i + 1];
				end
			end
			TOK_TWO: begin
				for (int i = 0; i < SPAN - 2; i++) begin
					shifted[i] = buf_win[i + 2];
				end
			end
			default: shifted = buf_win;
		endcase
	end

	ids_token #(
		.POSITION_BITS(POSITION_BITS)
	) u_token (
		.win         (buf_win),
		.avail       (avail),
		.flags       (flags_q),
		.text_pos    (pos_q),
		.dir_off     (dir_q),
		.quote_off   (quote_q),
		.angle_off   (angle_q),
		.line_cnt    (line_q),
		.flags_nx    (flags_nx),
		.text_pos_nx (pos_nx),
		.dir_off_nx  (dir_nx),
		.quote_off_nx(quote_nx),
		.angle_off_nx(angle_nx),
		.line_cnt_nx (line_nx),
		.tok_len     (tok_len),
		.hit         (hit),
		.record      (record)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fill_q      <= '0;
			flush_q     <= 1'b0;
			flush_hit_q <= 1'b0;
			flags_q     <= '0;
			pos_q       <= '0;
			dir_q       <= '0;
			quote_q     <= '0;
			angle_q     <= '0;
			line_q      <= 32'd1;
			rec_valid_q <= 1'b0;
		end else begin
			if (char_valid && char_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (rec_load) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end

			if (fire && char_s1.end_of_text) begin
				fill_q      <= avail;
				flush_q     <= 1'b1;
				flush_hit_q <= 1'b0;
			end else if (run_tok) begin
				fill_q <= avail - tok_len;
				if (step_flush && fill_q == tok_len) begin
					flush_q <= 1'b0;
				end
				if (rec_load && step_flush) begin
					flush_hit_q <= 1'b1;
				end
			end else if (fire) begin
				fill_q <= avail;
			end

			if (cfg_valid) begin
				line_q <= 32'(cfg_data);
			end else if (run_tok) begin
				line_q <= line_nx;
			end

			if (run_tok) begin
				flags_q <= flags_nx;
				pos_q   <= pos_nx;
				dir_q   <= dir_nx;
				quote_q <= quote_nx;
				angle_q <= angle_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_data;
		end
		if (run_tok) begin
			win_q <= shifted;
		end else if (fire) begin
			win_q <= buf_win;
		end
		if (rec_load) begin
			rec_q <= record;
		end
	end

endmodule

// ===== design/ids_checker.sv =====
// ----------------------------------------------------------------------------
// ids_checker
// Port-level checks on the include directive scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ids_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_ready,
	input ids_pkg::ids_in_t  char_data,
	input logic              rec_valid,
	input logic              rec_ready,
	input ids_pkg::ids_out_t rec_data,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic              cfg_data
);
	import ids_pkg::*;

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(rec_data))
		else $error("result word changed while stalled");

	a_rec_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rec_valid) |-> $past(rec_ready))
		else $error("result word dropped without being taken");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration word not taken at once");

	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !$isunknown(cfg_data))
		else $error("configuration word unknown");

	a_flush_stall: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && char_data.end_of_text ##1 char_valid && char_ready
		|=> !char_ready)
		else $error("byte taken during end-of-text flush");

endmodule

bind include_directive_scanner ids_checker u_ids_checker (.*);

// ===== verif/include_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// include_record_checker
// Watches the text, record and configuration channels of the include
// directive scanner. Every accepted text word is run through a local token
// scanner that keeps its own lookahead window, comment and directive flags,
// and counters. The include records it predicts are held in order and each
// accepted record is compared with the oldest one, field by field.
// ----------------------------------------------------------------------------
module include_record_checker
	import ids_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	input  logic     char_ready,
	input  ids_in_t  char_data,
	input  logic     rec_valid,
	input  logic     rec_ready,
	input  ids_out_t rec_data,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  logic     cfg_data,
	output int       mismatches,
	output int       outstanding
);

	ids_byte_t   window_bytes [SPAN];
	int          window_cnt;
	logic [31:0] text_pos;
	logic [31:0] line_no;
	logic [31:0] hash_at;
	logic [31:0] quote_at;
	logic [31:0] angle_at;
	ids_flags_t  fl;
	ids_out_t    records_due [$];

	function automatic bit pair_at(int n, int at, ids_byte_t c0, ids_byte_t c1);
		return at + 2 <= n && window_bytes[at] == c0 && window_bytes[at + 1] == c1;
	endfunction

	task automatic clear_line();
		fl.quote_open = 1'b0;
		fl.angle_open = 1'b0;
		fl.dir_open   = 1'b0;
		fl.in_incl    = 1'b0;
	endtask

	task automatic close_name(input logic [31:0] open_at, input logic sys,
			output ids_out_t rec);
		rec.line_number        = line_no;
		rec.directive_position = hash_at;
		rec.name_start         = open_at + 32'd1;
		rec.name_length        = text_pos - open_at - 32'd1;
		rec.is_system          = sys;
		fl.dir_open            = 1'b0;
		fl.in_incl             = 1'b0;
	endtask

	task automatic take_token(input int n, input int at, output int len, output bit hit,
			output ids_out_t rec);
		bit        hushed;
		bit        quoted;
		bit        kw;
		ids_byte_t c;
		hushed = fl.line_cmt || fl.block_cmt;
		quoted = fl.quote_open || fl.angle_open;
		c      = window_bytes[at];
		len    = 1;
		hit    = 1'b0;
		rec    = '0;
		kw     = at + KW_LEN <= n;
		for (int k = 0; k < KW_LEN; k++)
			if (kw && window_bytes[at + k] != KW_INCLUDE[k])
				kw = 1'b0;
		if (kw) begin
			if (!hushed && !fl.in_incl && !quoted && fl.dir_open)
				fl.in_incl = 1'b1;
			len = KW_LEN;
		end else if (c == CH_HASH) begin
			if (!quoted && !hushed) begin
				fl.dir_open = 1'b1;
				hash_at     = text_pos;
			end
		end else if (c == CH_QUOTE) begin
			if (fl.quote_open) begin
				if (!fl.angle_open) begin
					if (fl.in_incl) begin
						close_name(quote_at, 1'b0, rec);
						hit = 1'b1;
					end
					fl.quote_open = 1'b0;
				end
			end else if (!hushed && !fl.angle_open) begin
				fl.quote_open = 1'b1;
				quote_at      = text_pos;
			end
		end else if (c == CH_LT) begin
			if (!hushed && !quoted) begin
				fl.angle_open = 1'b1;
				angle_at      = text_pos;
			end
		end else if (c == CH_GT) begin
			if (fl.angle_open && !fl.quote_open) begin
				if (fl.in_incl) begin
					close_name(angle_at, 1'b1, rec);
					hit = 1'b1;
				end
				fl.angle_open = 1'b0;
			end
		end else if (pair_at(n, at, CH_SLASH, CH_SLASH)) begin
			if (!quoted && !hushed) begin
				fl.line_cmt = 1'b1;
				clear_line();
			end
			len = 2;
		end else if (pair_at(n, at, CH_SLASH, CH_STAR)) begin
			if (!quoted && !hushed) begin
				fl.block_cmt = 1'b1;
				clear_line();
			end
			len = 2;
		end else if (pair_at(n, at, CH_STAR, CH_SLASH)) begin
			if (fl.block_cmt) begin
				fl.block_cmt = 1'b0;
				fl.line_cmt  = 1'b0;
			end
			len = 2;
		end else if (c == CH_CR || c == CH_LF) begin
			if (pair_at(n, at, CH_CR, CH_LF))
				len = 2;
			fl.line_cmt = 1'b0;
			clear_line();
			line_no++;
		end
		text_pos = text_pos + 32'(len);
	endtask

	// resolve one token once the window is full, or all of it at end of text
	task automatic scan_word(input ids_in_t w);
		int       n;
		int       at;
		int       len;
		bit       hit;
		bit       taken;
		ids_out_t rec;
		n     = window_cnt + 1;
		at    = 0;
		taken = 1'b0;
		window_bytes[window_cnt] = w.text_byte;
		while (w.end_of_text ? at < n : (n == SPAN && at == 0)) begin
			take_token(n, at, len, hit, rec);
			at += len;
			if (hit && !taken) begin
				records_due.insert(records_due.size(), rec);
				taken = 1'b1;
			end
		end
		window_cnt = n - at;
		for (int k = 0; k < window_cnt; k++)
			window_bytes[k] = window_bytes[k + at];
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ids_out_t want;
		if (!arst_n) begin
			window_cnt = 0;
			text_pos   = '0;
			line_no    = 32'd1;
			hash_at    = '0;
			quote_at   = '0;
			angle_at   = '0;
			fl         = '0;
			records_due.delete();
			outstanding <= 0;
		end else begin
			if (rec_valid && rec_ready) begin
				if (records_due.size() == 0) begin
					$error("record with none expected: line %0d, name at %0d",
						rec_data.line_number, rec_data.name_start);
					mismatches++;
				end else begin
					want = records_due.pop_front();
					check_field("line_number", want.line_number, rec_data.line_number);
					check_field("directive_position", want.directive_position,
						rec_data.directive_position);
					check_field("name_start", want.name_start, rec_data.name_start);
					check_field("name_length", want.name_length, rec_data.name_length);
					check_field("is_system", want.is_system, rec_data.is_system);
				end
			end
			if (cfg_valid && cfg_ready)
				line_no = {31'b0, cfg_data};
			if (char_valid && char_ready)
				scan_word(char_data);
			outstanding <= records_due.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the include directive scanner with short source texts: a few fixed
// ones for the corner cases, then random texts built mostly from include
// lines in both forms, comments and line breaks, with noise and damaged
// lines mixed in. Both sides stall at random in the first two of three
// phases; between them the first line number is rewritten with the scanner idle.
// ----------------------------------------------------------------------------
module testbench;
	import ids_pkg::*;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_ready;
	ids_in_t   char_data  = '0;
	logic      rec_valid;
	logic      rec_ready  = 1'b0;
	ids_out_t  rec_data;
	logic      cfg_valid  = 1'b0;
	logic      cfg_ready;
	logic      cfg_data   = 1'b0;
	int        mismatches;
	int        outstanding;
	int        src_idle   = 0;
	int        sink_idle  = 0;
	int        words_sent = 0;
	ids_byte_t text_q [$];
	string     name_chars = "abcxyz_./019-";

	always #5 clk = ~clk;

	include_directive_scanner dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec_data   (rec_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	include_record_checker scan_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_data   (char_data),
		.rec_valid   (rec_valid),
		.rec_ready   (rec_ready),
		.rec_data    (rec_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		rec_ready <= $urandom_range(99) >= sink_idle;
	end

	task automatic send_word(input ids_byte_t b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= ids_in_t'({b, last});
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[k])
			send_word(text_q[k], k == text_q.size() - 1);
		text_q.delete();
	endtask

	// hold the text channel until every predicted record has arrived
	task automatic drain();
		char_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_first_line(input logic v);
		drain();
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic put_byte(input ids_byte_t b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic put_str(input string s);
		for (int k = 0; k < s.len(); k++)
			put_byte(s[k]);
	endtask

	task automatic put_gap();
		repeat ($urandom_range(2))
			put_byte($urandom_range(1) ? " " : "\t");
	endtask

	task automatic put_eol();
		case ($urandom_range(2))
			0: put_byte(CH_LF);
			1: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			default: put_byte(CH_CR);
		endcase
	endtask

	task automatic put_include();
		logic sys;
		sys = 1'($urandom_range(1));
		put_gap();
		put_byte(CH_HASH);
		put_gap();
		put_str("include");
		put_gap();
		put_byte(sys ? CH_LT : CH_QUOTE);
		repeat ($urandom_range(8))
			put_byte(name_chars[$urandom_range(name_chars.len() - 1)]);
		put_byte(sys ? CH_GT : CH_QUOTE);
	endtask

	task automatic put_line();
		int mark;
		mark = text_q.size();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				put_include();
				if ($urandom_range(3) == 0)
					put_str(" // t");
			end
			5: begin
				put_str($urandom_range(1) ? "// " : "/* ");
				put_include();
				put_str(" */");
			end
			6: begin
				put_str("/* a");
				put_eol();
				put_include();
				put_str(" */ ");
				put_include();
			end
			7: repeat ($urandom_range(1, 10))
				put_byte(8'($urandom_range(255)));
			8: begin
				put_include();
				text_q[$urandom_range(mark, text_q.size() - 1)] = 8'($urandom_range(255));
			end
			default: put_str("s = \"<q>\" < b > c; /");
		endcase
		put_eol();
	endtask

	// end the text on a full line, a partial token or an unterminated include
	task automatic random_text();
		repeat ($urandom_range(1, 5))
			put_line();
		case ($urandom_range(3))
			0: put_str("#incl");
			1: put_byte(CH_SLASH);
			2: put_include();
			default: ;
		endcase
		send_text();
	endtask

	task automatic run_phase(input int src, input int sink, input int count);
		int stop;
		src_idle  = src;
		sink_idle = sink;
		stop      = words_sent + count;
		random_text();
		drain();
		while (words_sent < stop)
			random_text();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		put_str("#include<>");
		put_byte(CH_CR);
		put_byte(CH_LF);
		send_text();
		put_str("#inclu");
		send_text();
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(CH_SLASH);
		send_text();
		put_byte(CH_CR);
		send_text();
		set_first_line(1'b0);
		run_phase(10, 80, 300);
		set_first_line(1'b1);
		run_phase(80, 10, 300);
		set_first_line(1'b0);
		run_phase(0, 0, 300);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ids_pkg.sv
design/ids_token.sv
design/include_directive_scanner.sv
design/ids_checker.sv
verif/include_record_checker.sv
verif/testbench.sv
